@@ hdl/ps2_mouse_packet_cursor_tracker_defines.svh @@
// Assertion macros shared by the PS/2 cursor tracker RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PS2MCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ps2mct: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PS2MCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ps2mct: next-cycle check failed");

`endif

@@ hdl/ps2mct_pkg.sv @@
// Shared types and constants for the PS/2 cursor tracker.
// No dependencies.
`default_nettype none

package ps2mct_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned CFG_BITS       = 13;
  localparam int unsigned NUM_SLOTS      = 4;

  localparam logic [CFG_BITS-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RST = 13'd480;

  // header bit positions
  localparam int unsigned HDR_LEFT   = 0;
  localparam int unsigned HDR_RIGHT  = 1;
  localparam int unsigned HDR_MIDDLE = 2;
  localparam int unsigned HDR_SYNC   = 3;
  localparam int unsigned HDR_XSIGN  = 4;
  localparam int unsigned HDR_YSIGN  = 5;
  localparam int unsigned HDR_XOVF   = 6;
  localparam int unsigned HDR_YOVF   = 7;

  // event slots in emission order
  localparam int unsigned SLOT_LEFT   = 0;
  localparam int unsigned SLOT_MIDDLE = 1;
  localparam int unsigned SLOT_RIGHT  = 2;
  localparam int unsigned SLOT_MOVE   = 3;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } ps2mct_cfg_e;

  typedef enum logic [1:0] {
    KIND_MOVE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } ps2mct_kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } ps2mct_phase_e;

  // events of one packet, handed to the event queue
  typedef struct packed {
    logic [NUM_SLOTS-1:0] pend;
    logic [2:0]           held;
  } ps2mct_evset_t;

endpackage

`default_nettype wire

@@ hdl/ps2mct_axis.sv @@
// One cursor axis: delta decode, position update and clamp to the screen.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_axis #(
  parameter int unsigned CoordBits = ps2mct_pkg::COORD_BITS_DEF
) (
  input  wire logic [CoordBits-1:0]            pos_i,
  input  wire logic [7:0]                      delta_i,
  input  wire logic                            neg_i,
  input  wire logic                            ovf_i,
  input  wire logic                            sub_i,
  input  wire logic [ps2mct_pkg::CFG_BITS-1:0] limit_i,
  output logic      [CoordBits-1:0]            pos_o
);

  localparam int unsigned VW = (CoordBits + 2 > ps2mct_pkg::CFG_BITS + 2) ?
                               CoordBits + 2 : ps2mct_pkg::CFG_BITS + 2;

  logic [8:0]                      mag_base;
  logic [9:0]                      mag;
  logic [ps2mct_pkg::CFG_BITS-1:0] lim_raw;
  logic signed [VW-1:0]            pos_s, mag_s, sum_s, lim_s, full_s, cap_s, res_s;

  always_comb begin
    // a set sign bit gives 256 minus the byte, so zero means 256
    mag_base = neg_i ? 9'(9'd256 - {1'b0, delta_i}) : {1'b0, delta_i};
    mag      = {1'b0, mag_base} + (ovf_i ? 10'd255 : 10'd0);
    pos_s    = VW'({1'b0, pos_i});
    mag_s    = VW'(mag);
    sum_s    = sub_i ? pos_s - mag_s : pos_s + mag_s;

    lim_raw  = (limit_i == '0) ? ps2mct_pkg::CFG_BITS'(1) : limit_i;
    lim_s    = VW'(lim_raw);
    full_s   = VW'(1) << CoordBits;
    cap_s    = (lim_s > full_s) ? full_s : lim_s;

    if (sum_s < 0) begin
      res_s = '0;
    end else if (sum_s >= cap_s) begin
      res_s = cap_s - VW'(1);
    end else begin
      res_s = sum_s;
    end
    pos_o = res_s[CoordBits-1:0];
  end

endmodule

`default_nettype wire

@@ hdl/ps2mct_evq.sv @@
// Event queue: holds the events of one packet and issues them one word a cycle
// while out_ready_i is high, through a registered output stage. Depends on ps2mct_pkg and the defines header.
`default_nettype none
`include "ps2_mouse_packet_cursor_tracker_defines.svh"

module ps2mct_evq #(
  parameter int unsigned CoordBits = ps2mct_pkg::COORD_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire ps2mct_pkg::ps2mct_evset_t set_i,
  input  wire logic [CoordBits-1:0]      x_i,
  input  wire logic [CoordBits-1:0]      y_i,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [1:0]                     event_kind_o,
  output logic [CoordBits-1:0]           cursor_x_o,
  output logic [CoordBits-1:0]           cursor_y_o,
  output logic [2:0]                     button_bits_o,
  output logic                           last_event_o
);

  localparam int unsigned NS = ps2mct_pkg::NUM_SLOTS;

  logic [NS-1:0]        pend_q, pend_d, sel;
  logic [2:0]           held_q;
  logic [CoordBits-1:0] x_q, y_q;
  logic                 take;

  logic                 out_valid_q, out_valid_d;
  logic [1:0]           kind_q, kind_d;
  logic [CoordBits-1:0] ox_q, oy_q;
  logic [2:0]           bits_q, bits_d;
  logic                 last_q, last_d;

  always_comb begin
    // lowest pending slot goes first: left, middle, right, then move
    sel  = pend_q & (~pend_q + NS'(1));
    take = (pend_q != '0) && (!out_valid_q || out_ready_i);

    pend_d = pend_q;
    if (load_i) begin
      pend_d = set_i.pend;
    end else if (take) begin
      pend_d = pend_q & ~sel;
    end

    if (sel[ps2mct_pkg::SLOT_MOVE]) begin
      kind_d = ps2mct_pkg::KIND_MOVE;
      bits_d = held_q;
    end else begin
      kind_d = ((held_q & sel[2:0]) != '0) ? ps2mct_pkg::KIND_PRESS
                                            : ps2mct_pkg::KIND_RELEASE;
      bits_d = sel[2:0];
    end
    last_d = ((pend_q & ~sel) == '0);

    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      held_q <= set_i.held;
      x_q    <= x_i;
      y_q    <= y_i;
    end
    if (take) begin
      kind_q <= kind_d;
      bits_q <= bits_d;
      last_q <= last_d;
      ox_q   <= x_q;
      oy_q   <= y_q;
    end
  end

  assign busy_o        = (pend_q != '0);
  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign cursor_x_o    = ox_q;
  assign cursor_y_o    = oy_q;
  assign button_bits_o = bits_q;
  assign last_event_o  = last_q;

  `PS2MCT_ASSERT_IMP(a_load_when_empty, load_i, pend_q == '0)
  `PS2MCT_ASSERT_NEXT(a_last_drains, take && last_d, pend_q == '0)
  `PS2MCT_ASSERT_IMP(a_button_onehot,
    out_valid_q && (kind_q != ps2mct_pkg::KIND_MOVE), $onehot(bits_q))

endmodule

`default_nettype wire

@@ hdl/ps2_mouse_packet_cursor_tracker.sv @@
// PS/2 mouse packet decoder and cursor tracker, top level.
// Depends on ps2mct_pkg, ps2mct_axis, ps2mct_evq and the defines header.
//
//   channel  | direction | handshake              | word
//   ---------+-----------+------------------------+----------------------------------
//   rx       | in        | in_valid_i/in_ready_o  | rx_byte_i
//   event    | out       | out_valid_o/out_ready_i| kind, cursor x/y, buttons, last
//   config   | in        | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// A byte is taken every cycle, except that a third byte waits while the previous
// packet's events are still queued; the packet is decoded and the cursor updated
// in the cycle the third byte is taken. Its up to four events leave the event
// queue one a cycle while out_ready_i is high. Reset gives 640 by 480, cursor at
// the origin, no buttons held, waiting for a header byte.
`default_nettype none
`include "ps2_mouse_packet_cursor_tracker_defines.svh"

module ps2_mouse_packet_cursor_tracker #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      rx_byte_i,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [ps2mct_pkg::CFG_BITS-1:0] cfg_wdata_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [1:0]                           event_kind_o,
  output logic [COORD_BITS-1:0]                cursor_x_o,
  output logic [COORD_BITS-1:0]                cursor_y_o,
  output logic [2:0]                           button_bits_o,
  output logic                                 last_event_o
);

  ps2mct_pkg::ps2mct_phase_e phase_q, phase_d;

  logic [ps2mct_pkg::CFG_BITS-1:0] width_q, height_q;
  logic [7:0]                      hdr_q, dx_q;
  logic [COORD_BITS-1:0]           pos_x_q, pos_y_q, new_x, new_y;
  logic [2:0]                      held_q, held_new;
  logic                            accept, busy, packet_done;
  ps2mct_pkg::ps2mct_evset_t       evset;

  assign in_ready_o = (phase_q != ps2mct_pkg::PH_DY) || !busy;
  assign accept     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        ps2mct_pkg::PH_DX: phase_d = ps2mct_pkg::PH_DY;
        ps2mct_pkg::PH_DY: phase_d = ps2mct_pkg::PH_HEADER;
        default: begin
          // drop bytes until one carries the sync bit
          phase_d = rx_byte_i[ps2mct_pkg::HDR_SYNC] ? ps2mct_pkg::PH_DX
                                                    : ps2mct_pkg::PH_HEADER;
        end
      endcase
    end
  end

  ps2mct_axis #(.CoordBits(COORD_BITS)) u_axis_x (
    .pos_i   (pos_x_q),
    .delta_i (dx_q),
    .neg_i   (hdr_q[ps2mct_pkg::HDR_XSIGN]),
    .ovf_i   (hdr_q[ps2mct_pkg::HDR_XOVF]),
    .sub_i   (hdr_q[ps2mct_pkg::HDR_XSIGN]),
    .limit_i (width_q),
    .pos_o   (new_x)
  );

  // rows grow downward, so Y moves against its sign
  ps2mct_axis #(.CoordBits(COORD_BITS)) u_axis_y (
    .pos_i   (pos_y_q),
    .delta_i (rx_byte_i),
    .neg_i   (hdr_q[ps2mct_pkg::HDR_YSIGN]),
    .ovf_i   (hdr_q[ps2mct_pkg::HDR_YOVF]),
    .sub_i   (!hdr_q[ps2mct_pkg::HDR_YSIGN]),
    .limit_i (height_q),
    .pos_o   (new_y)
  );

  // outputs of the packet decode
  always_comb begin
    packet_done = accept && (phase_q == ps2mct_pkg::PH_DY);
    held_new = {hdr_q[ps2mct_pkg::HDR_RIGHT], hdr_q[ps2mct_pkg::HDR_MIDDLE],
                hdr_q[ps2mct_pkg::HDR_LEFT]};
    evset.pend = {(new_x != pos_x_q) || (new_y != pos_y_q), held_new ^ held_q};
    evset.held = held_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ps2mct_pkg::PH_HEADER;
      width_q  <= ps2mct_pkg::WIDTH_RST;
      height_q <= ps2mct_pkg::HEIGHT_RST;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      held_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ps2mct_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
          ps2mct_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (packet_done) begin
        pos_x_q <= new_x;
        pos_y_q <= new_y;
        held_q  <= held_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (phase_q == ps2mct_pkg::PH_DX)) begin
      dx_q <= rx_byte_i;
    end
    if (accept && (phase_q != ps2mct_pkg::PH_DX) && (phase_q != ps2mct_pkg::PH_DY) &&
        rx_byte_i[ps2mct_pkg::HDR_SYNC]) begin
      hdr_q <= rx_byte_i;
    end
  end

  ps2mct_evq #(.CoordBits(COORD_BITS)) u_evq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (packet_done),
    .set_i         (evset),
    .x_i           (new_x),
    .y_i           (new_y),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .button_bits_o (button_bits_o),
    .last_event_o  (last_event_o)
  );

  `PS2MCT_ASSERT_IMP(a_stall_only_on_dy, !in_ready_o,
    (phase_q == ps2mct_pkg::PH_DY) && busy)
  `PS2MCT_ASSERT_NEXT(a_button_change_queued,
    packet_done && (held_new != held_q), busy)
  `PS2MCT_ASSERT_NEXT(a_packet_restarts, packet_done,
    phase_q == ps2mct_pkg::PH_HEADER)

endmodule

`default_nettype wire

@@ tb/tb_ps2_mouse_packet_cursor_tracker.sv @@
// Self-checking testbench for ps2_mouse_packet_cursor_tracker: streams mouse bytes, predicts
// press, release and move words, and compares each one as it leaves. Depends on ps2mct_pkg.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor_tracker;

  localparam int unsigned CB = ps2mct_pkg::COORD_BITS_DEF;
  localparam int unsigned CW = ps2mct_pkg::CFG_BITS;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    ps2mct_pkg::ps2mct_kind_e kind;
    logic [CB-1:0]            x;
    logic [CB-1:0]            y;
    logic [2:0]               buttons;
    logic                     last;
  } mouse_event_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [7:0]              rx_byte_i = 8'h00;
  logic                    cfg_we_i = 1'b0;
  ps2mct_pkg::ps2mct_cfg_e cfg_idx_i = ps2mct_pkg::CFG_WIDTH;
  logic [CW-1:0]           cfg_wdata_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [1:0]              event_kind_o;
  logic [CB-1:0]           cursor_x_o;
  logic [CB-1:0]           cursor_y_o;
  logic [2:0]              button_bits_o;
  logic                    last_event_o;

  ps2_mouse_packet_cursor_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .button_bits_o (button_bits_o),
    .last_event_o  (last_event_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the tracker
  logic [CW-1:0]             scr_w = ps2mct_pkg::WIDTH_RST;
  logic [CW-1:0]             scr_h = ps2mct_pkg::HEIGHT_RST;
  ps2mct_pkg::ps2mct_phase_e frame_phase = ps2mct_pkg::PH_HEADER;
  logic [7:0]                hdr_latch = 8'h00;
  logic [7:0]                dx_latch = 8'h00;
  int                        cur_x = 0;
  int                        cur_y = 0;
  logic [2:0]                held_mask = 3'b000;

  logic [7:0]   rx_backlog[$];
  mouse_event_t pending_events[$];
  mouse_event_t seen_events[$];

  int bytes_taken = 0;
  int events_checked = 0;
  int cfg_writes = 0;
  int failures = 0;
  int send_wait = 0;
  int send_calm = 0;
  int take_wait = 0;
  int take_calm = 0;
  int quiet_cycles = 0;
  mouse_event_t seen_ev;
  mouse_event_t got_ev;
  mouse_event_t want_ev;

  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic int clamp_axis(input int v, input logic [CW-1:0] lim_raw);
    int lim;
    lim = int'(lim_raw);
    if (lim == 0) lim = 1;
    if (lim > (1 << CB)) lim = 1 << CB;
    if (v < 0) v = 0;
    if (v >= lim) v = lim - 1;
    return v;
  endfunction

  function automatic mouse_event_t event_at(input ps2mct_pkg::ps2mct_kind_e kind,
                                            input logic [2:0] bits);
    mouse_event_t ev;
    ev.kind = kind;
    ev.x = CB'(cur_x);
    ev.y = CB'(cur_y);
    ev.buttons = bits;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Advance the shadow by one byte; a completed packet queues its words.
  function automatic void decode_mouse_byte(input logic [7:0] b);
    int mx, my, old_x, old_y, n;
    logic down;
    logic [2:0] btn;
    mouse_event_t ev[4];
    case (frame_phase)
      ps2mct_pkg::PH_DX: begin
        dx_latch = b;
        frame_phase = ps2mct_pkg::PH_DY;
      end
      ps2mct_pkg::PH_DY: begin
        frame_phase = ps2mct_pkg::PH_HEADER;
        old_x = cur_x;
        old_y = cur_y;
        n = 0;
        mx = hdr_latch[ps2mct_pkg::HDR_XSIGN] ? 256 - int'(dx_latch) : int'(dx_latch);
        if (hdr_latch[ps2mct_pkg::HDR_XOVF]) mx += 255;
        my = hdr_latch[ps2mct_pkg::HDR_YSIGN] ? 256 - int'(b) : int'(b);
        if (hdr_latch[ps2mct_pkg::HDR_YOVF]) my += 255;
        // screen rows grow downward, so Y runs against its sign
        cur_x = hdr_latch[ps2mct_pkg::HDR_XSIGN] ? cur_x - mx : cur_x + mx;
        cur_y = hdr_latch[ps2mct_pkg::HDR_YSIGN] ? cur_y + my : cur_y - my;
        cur_x = clamp_axis(cur_x, scr_w);
        cur_y = clamp_axis(cur_y, scr_h);
        for (int s = ps2mct_pkg::SLOT_LEFT; s <= ps2mct_pkg::SLOT_RIGHT; s++) begin
          btn = 3'b001 << s;
          down = (s == ps2mct_pkg::SLOT_LEFT)   ? hdr_latch[ps2mct_pkg::HDR_LEFT] :
                 (s == ps2mct_pkg::SLOT_MIDDLE) ? hdr_latch[ps2mct_pkg::HDR_MIDDLE] :
                                                  hdr_latch[ps2mct_pkg::HDR_RIGHT];
          if (down != |(held_mask & btn)) begin
            ev[n] = event_at(down ? ps2mct_pkg::KIND_PRESS : ps2mct_pkg::KIND_RELEASE, btn);
            n++;
          end
          held_mask = down ? (held_mask | btn) : (held_mask & ~btn);
        end
        if (cur_x != old_x || cur_y != old_y) begin
          ev[n] = event_at(ps2mct_pkg::KIND_MOVE, held_mask);
          n++;
        end
        for (int i = 0; i < n; i++) begin
          ev[i].last = (i == n - 1);
          pending_events.push_back(ev[i]);
        end
      end
      default: begin
        // anything without the sync bit is dropped while hunting for a header
        if (b[ps2mct_pkg::HDR_SYNC]) begin
          hdr_latch = b;
          frame_phase = ps2mct_pkg::PH_DX;
        end else begin
          frame_phase = ps2mct_pkg::PH_HEADER;
        end
      end
    endcase
  endfunction

  task automatic flag_event_mismatch(input string why, input mouse_event_t got,
                                     input mouse_event_t want);
    failures++;
    $display("%0t mismatch (%s): got %0d/%0d/%0d/%b/%b, want %0d/%0d/%0d/%b/%b",
             $time, why, got.kind, got.x, got.y, got.buttons, got.last,
             want.kind, want.x, want.y, want.buttons, want.last);
  endtask

  // Sender: hold each word until taken, then idle for the drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
      send_wait  <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_mouse_byte(rx_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_wait > 0) begin
          send_wait  <= send_wait - 1;
          in_valid_i <= 1'b0;
        end else if (rx_backlog.size() > 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_backlog.pop_front();
          send_wait  <= pick_wait(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: capture each word taken, stall ready for the drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      take_wait = 0;
    end else if (out_valid_o && out_ready_i) begin
      seen_ev.kind    = ps2mct_pkg::ps2mct_kind_e'(event_kind_o);
      seen_ev.x       = cursor_x_o;
      seen_ev.y       = cursor_y_o;
      seen_ev.buttons = button_bits_o;
      seen_ev.last    = last_event_o;
      seen_events.push_back(seen_ev);
      take_wait = pick_wait(take_calm);
      out_ready_i <= (take_wait == 0);
    end else if (take_wait > 0) begin
      take_wait = take_wait - 1;
      out_ready_i <= (take_wait == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare away from the clock edge so capture and prediction have both settled.
  always @(negedge clk_i) begin
    if (seen_events.size() > 0) begin
      got_ev = seen_events.pop_front();
      events_checked++;
      if (pending_events.size() == 0) begin
        flag_event_mismatch("no word expected", got_ev, got_ev);
      end else begin
        want_ev = pending_events.pop_front();
        if (got_ev.kind !== want_ev.kind || got_ev.x !== want_ev.x ||
            got_ev.y !== want_ev.y || got_ev.buttons !== want_ev.buttons ||
            got_ev.last !== want_ev.last)
          flag_event_mismatch("field differs", got_ev, want_ev);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t no handshake for %0d cycles, %0d words still expected",
               $time, quiet_cycles, pending_events.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] dx,
                              input logic [7:0] dy);
    rx_backlog.push_back(hdr);
    rx_backlog.push_back(dx);
    rx_backlog.push_back(dy);
  endtask

  function automatic logic [7:0] pick_delta(input logic neg);
    case ($urandom_range(0, 3))
      0: return neg ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 15));
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly whole packets with random content; some dropped bytes and stray
  // headers knock the framing out of step.
  task automatic queue_random(input int want, input bit drift);
    int made, pick;
    logic [7:0] hdr;
    made = 0;
    while (made < want) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        rx_backlog.push_back(8'($urandom) & 8'hF7);
        made++;
      end else if (pick == 2) begin
        rx_backlog.push_back(8'($urandom) | 8'h08);
        made++;
      end else begin
        hdr = 8'($urandom) | 8'h08;
        if (drift && $urandom_range(0, 3) != 0) begin
          hdr[ps2mct_pkg::HDR_XSIGN] = 1'b0;
          hdr[ps2mct_pkg::HDR_YSIGN] = 1'b1;
        end
        queue_packet(hdr, pick_delta(hdr[ps2mct_pkg::HDR_XSIGN]),
                     pick_delta(hdr[ps2mct_pkg::HDR_YSIGN]));
        made += 3;
      end
    end
  endtask

  // Hold off until every queued byte is taken and every expected word has come.
  task automatic settle();
    @(negedge clk_i);
    while (rx_backlog.size() > 0 || in_valid_i) @(negedge clk_i);
    while (pending_events.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_screen(input logic [CW-1:0] w, input logic [CW-1:0] h);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ps2mct_pkg::CFG_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= ps2mct_pkg::CFG_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scr_w = w;
    scr_h = h;
    cfg_writes += 2;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, on the reset screen of 640 by 480
    rx_backlog.push_back(8'h00);
    rx_backlog.push_back(8'hF7);
    queue_packet(8'h08, 8'h00, 8'h00);  // still packet: nothing to say
    queue_packet(8'h0F, 8'hFF, 8'h00);  // all three pressed, largest plain step
    queue_packet(8'h08, 8'hFF, 8'h01);  // all released, Y pinned at the top
    queue_packet(8'h38, 8'h00, 8'h00);  // zero byte with sign set moves 256
    queue_packet(8'hC8, 8'hFF, 8'hFF);  // both overflows, X pinned at the right
    queue_packet(8'hF9, 8'h80, 8'h7F);  // sign plus overflow on both axes
    queue_packet(8'h09, 8'h00, 8'h00);  // button held, no move: no word at all
    settle();

    set_screen(13'd1, 13'd1);
    queue_random(40, 1'b0);
    settle();
    set_screen(13'd4096, 13'd4096);
    queue_random(60, 1'b1);
    queue_random(40, 1'b0);
    settle();
    set_screen(13'd0, 13'd8191);
    queue_random(40, 1'b1);
    settle();
    set_screen(13'($urandom_range(2, 4095)), 13'($urandom_range(2, 4095)));
    queue_random(80, 1'b0);
    settle();
    set_screen(13'($urandom_range(4097, 8191)), 13'($urandom_range(1, 64)));
    queue_random(70, 1'b1);
    settle();

    @(negedge clk_i);
    if (pending_events.size() > 0) begin
      $display("%0d expected words never arrived", pending_events.size());
      failures += pending_events.size();
    end
    $display("Covered %0d mouse bytes and %0d event words over %0d register writes,",
             bytes_taken, events_checked, cfg_writes);
    $display("screens from zero width up to past 4096, with %0d failures", failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
